/* rtl/running_gauss_background_model_assert.svh */
// Assertion macros shared by the running Gaussian background model RTL.
`ifndef RUNNING_GAUSS_BACKGROUND_MODEL_ASSERT_SVH
`define RUNNING_GAUSS_BACKGROUND_MODEL_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RGBM_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define RGBM_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rgbm_pkg.sv */
// Package: types, codes and constants of the running Gaussian background model.
`timescale 1ns / 1ps
package rgbm_pkg;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    localparam logic [1:0] CFG_ALPHA     = 2'd0;
    localparam logic [1:0] CFG_INIT_MEAN = 2'd1;
    localparam logic [1:0] CFG_INIT_VAR  = 2'd2;

    localparam logic [15:0] ALPHA_RST    = 16'd52429;   // 0.8 in Q0.16
    localparam logic [31:0] INIT_VAR_RST = 32'd65536;   // 1.0 in Q16.16
    localparam logic [31:0] VAR_FLOOR    = 32'd32768;   // 0.5 in Q16.16
    localparam logic [31:0] ONE_Q31      = 32'h8000_0000;
    localparam logic [3:0]  EXP_TERMS    = 4'd14;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LD0,
        ST_LD1,
        ST_U0,
        ST_U1,
        ST_BLEND,
        ST_BLEND_END,
        ST_VAR0,
        ST_VAR1,
        ST_D0,
        ST_D1,
        ST_DIV,
        ST_EXP_INIT,
        ST_E_MUL,
        ST_E_P,
        ST_E_Q,
        ST_E_C,
        ST_SQ,
        ST_SQ_W,
        ST_CONF,
        ST_FIN
    } rgbm_state_t;

    // floor(2^32 / k) for the series divisors; q0 = (p * R) >> 32 is q or q - 1
    function automatic logic [31:0] recip_k(input logic [3:0] k);
        logic [31:0] r;
        begin
            unique case (k)
                4'd2:    r = 32'd2147483648;
                4'd3:    r = 32'd1431655765;
                4'd4:    r = 32'd1073741824;
                4'd5:    r = 32'd858993459;
                4'd6:    r = 32'd715827882;
                4'd7:    r = 32'd613566756;
                4'd8:    r = 32'd536870912;
                4'd9:    r = 32'd477218588;
                4'd10:   r = 32'd429496729;
                4'd11:   r = 32'd390451572;
                4'd12:   r = 32'd357913941;
                4'd13:   r = 32'd330382099;
                4'd14:   r = 32'd306783378;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

/* rtl/rgbm_mul.sv */
// Shared 32x32 unsigned multiplier with registered product.
`timescale 1ns / 1ps
module rgbm_mul
    import rgbm_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);

    logic [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= 64'(a) * 64'(b);
    end

    assign p = p_reg;

endmodule

/* rtl/running_gauss_background_model.sv */
// Running Gaussian background model: top level with sequencer and model state.
// Update item: blend of mean and second moment, variance, confidence; a far sample
// or an exponent of 16 or more skips to the result. Load item: sets the model, or
// only returns the result if already loaded. One item at a time; a stalled result
// waits. Cost is set by the single shared 32x32 multiplier (blend, squares, series,
// reciprocal division) and the 20-step bit-per-cycle exponent divider.
// rst_n (async, active low) clears the model to mean 0, variance 0.5, not loaded,
// and restores the register defaults.
`timescale 1ns / 1ps
`include "running_gauss_background_model_assert.svh"
module running_gauss_background_model
    import rgbm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    // config write channel
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [1:0]                              cfg_index,
    input  logic [31:0]                             cfg_data,
    // input stream
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // [SW-1:0] sample, zero pad
    input  logic [0:0]                              s_tuser,  // [0] command
    // output stream
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [63:0]                             m_tdata   // confidence, mean_out,
                                                               // variance_out
);

    localparam int SAT_HI_I = (1 << (SAMPLE_WIDTH - 1)) - 1;
    localparam int SAT_LO_I = -(1 << (SAMPLE_WIDTH - 1));
    localparam int XS_PAD   = 33 - SAMPLE_WIDTH - 8;

    // ---------------- configuration registers ----------------
    logic [15:0] alpha_reg;
    logic [15:0] init_mean_reg;
    logic [31:0] init_var_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg     <= ALPHA_RST;
            init_mean_reg <= 16'd0;
            init_var_reg  <= INIT_VAR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_ALPHA)
                alpha_reg <= cfg_data[15:0];
            else if (cfg_index == CFG_INIT_MEAN)
                init_mean_reg <= cfg_data[15:0];
            else if (cfg_index == CFG_INIT_VAR)
                init_var_reg <= cfg_data;
        end
    end

    // ---------------- state ----------------
    rgbm_state_t state_reg, state_next;

    logic               loaded_reg, loaded_next;
    logic signed [32:0] mean_reg, mean_next;        // Q.16
    logic [62:0]        sm_reg, sm_next;            // second moment, Q.32
    logic [31:0]        var_reg, var_next;          // Q16.16

    logic               cmd_reg, cmd_next;
    logic signed [32:0] xs_reg, xs_next;            // sample in Q.16
    logic [31:0]        ax_reg, ax_next;            // |sample| Q.8
    logic [63:0]        nsq_reg, nsq_next;          // new second-moment sample
    logic [79:0]        acc_reg, acc_next;
    logic [1:0]         ph_reg, ph_next;
    logic               bsel_reg, bsel_next;        // 0: mean blend, 1: moment blend
    logic [30:0]        ad_reg, ad_next;
    logic [53:0]        rem_reg, rem_next;
    logic [53:0]        dsh_reg, dsh_next;
    logic [19:0]        q_reg, q_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [30:0]        y_reg, y_next;
    logic [31:0]        term_reg, term_next;
    logic [31:0]        sum_reg, sum_next;
    logic [3:0]         k_reg, k_next;
    logic [31:0]        pp_reg, pp_next;
    logic [31:0]        q0_reg, q0_next;
    logic [15:0]        conf_reg, conf_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [63:0]        m_tdata_reg, m_tdata_next;

    // shared multiplier
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    rgbm_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- datapath helpers ----------------
    logic signed [SAMPLE_WIDTH-1:0] smp;
    logic [SAMPLE_WIDTH-1:0]        smp_abs;
    logic [16:0]                    nw;
    logic [33:0]                    mean_b;
    logic [33:0]                    xs_b;
    logic [63:0]                    old_v;
    logic [63:0]                    new_v;
    logic [79:0]                    blend_sum;
    logic [63:0]                    blend_res;
    logic [32:0]                    mean_abs;
    logic [33:0]                    d_full;
    logic [33:0]                    d_abs;
    logic [63:0]                    var_diff;
    logic [63:0]                    var_rnd;
    logic [31:0]                    var_sat;
    logic [32:0]                    div2;
    logic                           div_ge;
    logic [31:0]                    tnew;
    logic                           do_acc;
    logic [63:0]                    sq_rnd;
    logic [32:0]                    conf_rnd;
    logic [15:0]                    im_abs;
    logic signed [33:0]             mr_full;
    logic signed [25:0]             mr;
    logic signed [25:0]             mr_sat;

    always_comb
    begin
        smp     = $signed(s_tdata[SAMPLE_WIDTH-1:0]);
        smp_abs = smp[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-smp) : SAMPLE_WIDTH'(smp);
        nw      = 17'h1_0000 - {1'b0, alpha_reg};
        // biased by 2^32 so the blend runs on unsigned operands
        mean_b  = {mean_reg[32], mean_reg} + 34'h1_0000_0000;
        xs_b    = {xs_reg[32], xs_reg} + 34'h1_0000_0000;
        old_v   = bsel_reg ? {1'b0, sm_reg} : {30'd0, mean_b};
        new_v   = bsel_reg ? nsq_reg : {30'd0, xs_b};
        // last limb product (new upper word) lands at bit 32
        blend_sum = acc_reg + {mul_p[47:0], 32'd0} + 80'd32768;
        blend_res = blend_sum[79:16];
        mean_abs  = mean_reg[32] ? 33'(-mean_reg) : 33'(mean_reg);
        d_full    = {xs_reg[32], xs_reg} - {mean_reg[32], mean_reg};
        d_abs     = d_full[33] ? -d_full : d_full;
        var_diff  = {1'b0, sm_reg} - mul_p;
        var_rnd   = (var_diff + 64'd32768) >> 16;
        if ({1'b0, sm_reg} <= mul_p)
            var_sat = 32'd0;
        else if (var_rnd[63:32] != 32'd0)
            var_sat = 32'hFFFF_FFFF;
        else
            var_sat = var_rnd[31:0];
        if (var_sat < VAR_FLOOR)
            var_sat = VAR_FLOOR;
        div2     = {var_reg, 1'b0};
        div_ge   = (rem_reg >= dsh_reg);
        sq_rnd   = (mul_p + 64'h4000_0000) >> 31;
        conf_rnd = ({1'b0, sum_reg} + 33'd16384) >> 15;
        im_abs   = init_mean_reg[15] ? -init_mean_reg : init_mean_reg;
        // mean rounded half up to Q8.8, saturated to the sample range
        mr_full  = {mean_reg[32], mean_reg} + 34'sd128;
        mr       = mr_full[33:8];
        if (mr > $signed(26'(SAT_HI_I)))
            mr_sat = $signed(26'(SAT_HI_I));
        else if (mr < $signed(26'(SAT_LO_I)))
            mr_sat = $signed(26'(SAT_LO_I));
        else
            mr_sat = mr;
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next    = state_reg;
        loaded_next   = loaded_reg;
        mean_next     = mean_reg;
        sm_next       = sm_reg;
        var_next      = var_reg;
        cmd_next      = cmd_reg;
        xs_next       = xs_reg;
        ax_next       = ax_reg;
        nsq_next      = nsq_reg;
        acc_next      = acc_reg;
        ph_next       = ph_reg;
        bsel_next     = bsel_reg;
        ad_next       = ad_reg;
        rem_next      = rem_reg;
        dsh_next      = dsh_reg;
        q_next        = q_reg;
        cnt_next      = cnt_reg;
        y_next        = y_reg;
        term_next     = term_reg;
        sum_next      = sum_reg;
        k_next        = k_reg;
        pp_next       = pp_reg;
        q0_next       = q0_reg;
        conf_next     = conf_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        mul_a         = 32'd0;
        mul_b         = 32'd0;
        tnew          = 32'd0;
        do_acc        = 1'b0;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next = s_tuser[0];
                    xs_next  = $signed({{XS_PAD{smp[SAMPLE_WIDTH-1]}}, smp, 8'd0});
                    ax_next  = {{(32 - SAMPLE_WIDTH){1'b0}}, smp_abs};
                    conf_next = 16'd0;
                    if (s_tuser[0] == CMD_LOAD)
                        state_next = loaded_reg ? ST_FIN : ST_LD0;
                    else
                        state_next = ST_U0;
                end
            end
            ST_LD0:
            begin
                mul_a      = {16'd0, im_abs};
                mul_b      = {16'd0, im_abs};
                state_next = ST_LD1;
            end
            ST_LD1:
            begin
                sm_next     = 63'({mul_p[32:0] + {1'b0, init_var_reg}, 16'd0});
                mean_next   = $signed({{9{init_mean_reg[15]}}, init_mean_reg, 8'd0});
                var_next    = init_var_reg;
                loaded_next = 1'b1;
                state_next  = ST_FIN;
            end
            ST_U0:
            begin
                mul_a      = ax_reg;
                mul_b      = ax_reg;
                state_next = ST_U1;
            end
            ST_U1:
            begin
                nsq_next   = {mul_p[47:0], 16'd0};
                acc_next   = 80'd0;
                ph_next    = 2'd0;
                bsel_next  = 1'b0;
                state_next = ST_BLEND;
            end
            ST_BLEND:
            begin
                // issue one limb product per cycle, fold in the previous one
                unique case (ph_reg)
                    2'd0:
                    begin
                        mul_a = {16'd0, alpha_reg};
                        mul_b = old_v[31:0];
                    end
                    2'd1:
                    begin
                        mul_a = {16'd0, alpha_reg};
                        mul_b = old_v[63:32];
                        acc_next = acc_reg + {16'd0, mul_p};
                    end
                    2'd2:
                    begin
                        mul_a = {15'd0, nw};
                        mul_b = new_v[31:0];
                        acc_next = acc_reg + {mul_p[47:0], 32'd0};
                    end
                    default:
                    begin
                        mul_a = {15'd0, nw};
                        mul_b = new_v[63:32];
                        acc_next = acc_reg + {16'd0, mul_p};
                    end
                endcase
                ph_next = ph_reg + 2'd1;
                if (ph_reg == 2'd3)
                    state_next = ST_BLEND_END;
            end
            ST_BLEND_END:
            begin
                if (!bsel_reg)
                begin
                    mean_next  = $signed(blend_res[32:0] - 33'h1_0000_0000);
                    acc_next   = 80'd0;
                    ph_next    = 2'd0;
                    bsel_next  = 1'b1;
                    state_next = ST_BLEND;
                end
                else
                begin
                    sm_next    = blend_res[62:0];
                    state_next = ST_VAR0;
                end
            end
            ST_VAR0:
            begin
                mul_a      = mean_abs[31:0];
                mul_b      = mean_abs[31:0];
                state_next = ST_VAR1;
            end
            ST_VAR1:
            begin
                var_next = var_sat;
                ad_next  = d_abs[30:0];
                if (d_abs[33:31] != 3'd0)
                    state_next = ST_FIN;    // far sample, confidence stays 0
                else
                    state_next = ST_D0;
            end
            ST_D0:
            begin
                mul_a      = {1'b0, ad_reg};
                mul_b      = {1'b0, ad_reg};
                state_next = ST_D1;
            end
            ST_D1:
            begin
                // exponent of 16 or more gives zero confidence
                if (mul_p >= {11'd0, div2, 20'd0})
                    state_next = ST_FIN;
                else
                begin
                    rem_next   = mul_p[53:0];
                    dsh_next   = {2'd0, div2, 19'd0};
                    q_next     = 20'd0;
                    cnt_next   = 5'd19;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_ge)
                    rem_next = rem_reg - dsh_reg;
                q_next   = {q_reg[18:0], div_ge};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                    state_next = ST_EXP_INIT;
            end
            ST_EXP_INIT:
            begin
                y_next     = {q_reg, 11'd0};
                term_next  = ONE_Q31;
                sum_next   = ONE_Q31;
                k_next     = 4'd1;
                state_next = ST_E_MUL;
            end
            ST_E_MUL:
            begin
                mul_a      = term_reg;
                mul_b      = {1'b0, y_reg};
                state_next = ST_E_P;
            end
            ST_E_P:
            begin
                if (k_reg == 4'd1)
                begin
                    tnew   = mul_p[62:31];
                    do_acc = 1'b1;
                end
                else
                begin
                    pp_next    = mul_p[62:31];
                    mul_a      = mul_p[62:31];
                    mul_b      = recip_k(k_reg);
                    state_next = ST_E_Q;
                end
            end
            ST_E_Q:
            begin
                q0_next    = mul_p[63:32];
                mul_a      = mul_p[63:32];
                mul_b      = {28'd0, k_reg};
                state_next = ST_E_C;
            end
            ST_E_C:
            begin
                // reciprocal estimate may be one short
                if ((pp_reg - mul_p[31:0]) >= {28'd0, k_reg})
                    tnew = q0_reg + 32'd1;
                else
                    tnew = q0_reg;
                do_acc = 1'b1;
            end
            ST_SQ:
            begin
                mul_a      = sum_reg;
                mul_b      = sum_reg;
                state_next = ST_SQ_W;
            end
            ST_SQ_W:
            begin
                sum_next = sq_rnd[31:0];
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd3)
                    state_next = ST_CONF;
                else
                    state_next = ST_SQ;
            end
            ST_CONF:
            begin
                conf_next  = (conf_rnd[32:16] != 17'd0) ? 16'hFFFF : conf_rnd[15:0];
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {var_reg, mr_sat[15:0], conf_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // series accumulate: odd terms subtract, even terms add
        if (do_acc)
        begin
            term_next = tnew;
            sum_next  = k_reg[0] ? (sum_reg - tnew) : (sum_reg + tnew);
            if (k_reg == EXP_TERMS)
            begin
                cnt_next   = 5'd0;
                state_next = ST_SQ;
            end
            else
            begin
                k_next     = k_reg + 4'd1;
                state_next = ST_E_MUL;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            loaded_reg   <= 1'b0;
            mean_reg     <= 33'sd0;
            sm_reg       <= 63'd0;
            var_reg      <= VAR_FLOOR;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            loaded_reg   <= loaded_next;
            mean_reg     <= mean_next;
            sm_reg       <= sm_next;
            var_reg      <= var_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        xs_reg      <= xs_next;
        ax_reg      <= ax_next;
        nsq_reg     <= nsq_next;
        acc_reg     <= acc_next;
        ph_reg      <= ph_next;
        bsel_reg    <= bsel_next;
        ad_reg      <= ad_next;
        rem_reg     <= rem_next;
        dsh_reg     <= dsh_next;
        q_reg       <= q_next;
        cnt_reg     <= cnt_next;
        y_reg       <= y_next;
        term_reg    <= term_next;
        sum_reg     <= sum_next;
        k_reg       <= k_next;
        pp_reg      <= pp_next;
        q0_reg      <= q0_next;
        conf_reg    <= conf_next;
        m_tdata_reg <= m_tdata_next;
    end

    // ---------------- checks ----------------
    `RGBM_ASSERT_NXT(a_loaded_sticky, clk, rst_n, loaded_reg, loaded_reg, "model load flag dropped")
    `RGBM_ASSERT_NXT(a_var_floor, clk, rst_n, state_reg == ST_VAR1, var_reg >= VAR_FLOOR, "variance below floor")
    `RGBM_ASSERT_IMP(a_sum_bound, clk, rst_n, state_reg == ST_CONF, sum_reg <= ONE_Q31, "exp sum above one")
    `RGBM_ASSERT_NXT(a_busy_after_in, clk, rst_n, s_tvalid && s_tready, state_reg != ST_IDLE, "idle after transfer in")
    `RGBM_ASSERT_IMP(a_cmd_path, clk, rst_n, state_reg == ST_U0, cmd_reg == CMD_UPDATE, "update path on load")

endmodule
